// ===== rtl/lbp_pkg.sv =====
// Shared types and constants for the LBP code histogram block.
package lbp_pkg;

  // Line store and frame geometry
  localparam int MAX_COLS   = 1024;
  localparam int MAX_ROWS   = 1024;
  localparam int COL_BITS   = $clog2(MAX_COLS);
  localparam int ROW_BITS   = $clog2(MAX_ROWS);
  localparam int CFG_BITS   = 11;
  localparam int DIM_BITS   = (COL_BITS + 1 > CFG_BITS) ? COL_BITS + 1 : CFG_BITS;

  // Histogram
  localparam int NUM_BINS   = 256;
  localparam int BIN_BITS   = $clog2(NUM_BINS);
  localparam int COUNT_BITS = 20;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Field widths on the stream ports
  localparam int PIXEL_BITS   = 8;
  localparam int CODE_BITS    = 8;
  localparam int OUT_POS_BITS = 10;
  localparam int OUT_CNT_BITS = 20;
  localparam int OP_BITS      = 2;
  localparam int IN_DATA_BITS = PIXEL_BITS + BIN_BITS;
  localparam int OUT_DATA_BITS = CODE_BITS + 2 * OUT_POS_BITS + OUT_CNT_BITS;
  localparam int CFG_INDEX_BITS = 1;

  // Input operation codes
  localparam logic [OP_BITS-1:0] OP_PIXEL = 2'd0;
  localparam logic [OP_BITS-1:0] OP_READ  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  // Result kinds
  localparam logic KIND_CODE  = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_COLS = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_ROWS = 1'd1;

  // Configuration reset values
  localparam logic [CFG_BITS-1:0] COLS_RESET = 11'd30;
  localparam logic [CFG_BITS-1:0] ROWS_RESET = 11'd30;

  // Pipeline stage after accept: line store read in flight
  typedef struct packed {
    logic                    valid;
    logic [OP_BITS-1:0]      op;
    logic [PIXEL_BITS-1:0]   px;
    logic [BIN_BITS-1:0]     bin;
    logic                    interior;
    logic                    last;
    logic [COL_BITS-1:0]     col_addr;
    logic [OUT_POS_BITS-1:0] out_row;
    logic [OUT_POS_BITS-1:0] out_col;
  } stage1_t;

  // Pipeline stage after code: histogram read in flight
  typedef struct packed {
    logic                    valid;
    logic                    inc;
    logic                    rd;
    logic                    clear;
    logic [BIN_BITS-1:0]     addr;
    logic                    last;
    logic [OUT_POS_BITS-1:0] out_row;
    logic [OUT_POS_BITS-1:0] out_col;
  } stage2_t;

endpackage

// ===== rtl/lbp_ram.sv =====
// Generic simple dual port RAM with registered read.
module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/lbp_code_histogram_unit.sv =====
// LBP code histogram unit: 3x3 local binary patterns and a 256-bin code histogram.
//
// Input stream (s_*): one transaction per item. s_tuser carries the operation:
// pixel, read histogram bin, or clear histogram and restart the frame. Pixels
// arrive in raster order; image size comes from the image_cols and image_rows
// registers on the cfg_* write port, and a write restarts the frame.
// Output stream (m_*): one transaction per interior pixel code (m_tuser low,
// m_tlast on the last code of a frame) and per bin read (m_tuser high).
// Each input passes through stage 1, stage 2 and then the output register.
// Throughput: one item per clock unless the receiver stalls. The histogram
// read-modify-write goes through a registered-read RAM; a forwarding register
// covers back-to-back hits on the same bin. Line stores sit in one RAM read one
// pixel ahead of its write. Reset clears the frame position, the window and all
// bin valid flags at once, so the histogram reads zero without a clearing pass;
// a clear item does the same. When the receiver stalls the whole pipeline holds
// and s_tready drops only while a finished result waits and m_tready is low.
module lbp_code_histogram_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  // Input stream
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [lbp_pkg::IN_DATA_BITS-1:0]         s_tdata,  // pixel, bin_index
  input  logic [lbp_pkg::OP_BITS-1:0]              s_tuser,  // op
  // Output stream
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [lbp_pkg::OUT_DATA_BITS-1:0]        m_tdata,  // pattern_code, out_row,
                                                             // out_col, bin_count
  output logic                                     m_tuser,  // kind
  output logic                                     m_tlast,  // frame_last
  // Configuration write port
  input  logic                                     cfg_we,
  input  logic [lbp_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [lbp_pkg::CFG_BITS-1:0]             cfg_data
);

  import lbp_pkg::*;

  logic en;
  logic accept;

  logic [CFG_BITS-1:0] image_cols;
  logic [CFG_BITS-1:0] image_rows;
  logic [DIM_BITS-1:0] cols_eff;
  logic [DIM_BITS-1:0] rows_eff;

  logic [COL_BITS-1:0] col;
  logic [ROW_BITS-1:0] row;
  logic                col_end;
  logic                row_end;

  stage1_t s1;
  stage2_t s2;

  logic [PIXEL_BITS-1:0] window [6];

  logic [2*PIXEL_BITS-1:0] line_rdata;
  logic [PIXEL_BITS-1:0]   top;
  logic [PIXEL_BITS-1:0]   mid;
  logic [PIXEL_BITS-1:0]   centre;
  logic [CODE_BITS-1:0]    code;
  logic                    line_we;

  logic [COUNT_BITS-1:0] hist_rdata;
  logic [BIN_BITS-1:0]   hist_raddr;
  logic [NUM_BINS-1:0]   hist_valid;
  logic                  fwd_valid;
  logic [BIN_BITS-1:0]   fwd_addr;
  logic [COUNT_BITS-1:0] fwd_data;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic                  hist_we;

  // Pipeline moves when the output register is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols <= COLS_RESET;
      image_rows <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_COLS: image_cols <= cfg_data;
        REG_IMAGE_ROWS: image_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp image size to the supported range
  always_comb begin
    cols_eff = DIM_BITS'(image_cols);
    if (cols_eff < DIM_BITS'(3)) cols_eff = DIM_BITS'(3);
    if (cols_eff > DIM_BITS'(MAX_COLS)) cols_eff = DIM_BITS'(MAX_COLS);
    rows_eff = DIM_BITS'(image_rows);
    if (rows_eff < DIM_BITS'(3)) rows_eff = DIM_BITS'(3);
    if (rows_eff > DIM_BITS'(MAX_ROWS)) rows_eff = DIM_BITS'(MAX_ROWS);
  end

  assign col_end = DIM_BITS'(col) == cols_eff - DIM_BITS'(1);
  assign row_end = DIM_BITS'(row) == rows_eff - DIM_BITS'(1);

  // Raster position of the next pixel
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      case (s_tuser)
        OP_PIXEL: begin
          if (col_end) begin
            col <= '0;
            row <= row_end ? '0 : row + ROW_BITS'(1);
          end else begin
            col <= col + COL_BITS'(1);
          end
        end
        OP_CLEAR: begin
          col <= '0;
          row <= '0;
        end
        default: ;
      endcase
    end
  end

  // Stage 1: capture the item while the line store read is in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (en) begin
      s1.valid <= s_tvalid;
    end
    if (en) begin
      s1.op       <= s_tuser;
      s1.px       <= s_tdata[PIXEL_BITS-1:0];
      s1.bin      <= s_tdata[IN_DATA_BITS-1:PIXEL_BITS];
      s1.interior <= (row >= ROW_BITS'(2)) && (col >= COL_BITS'(2));
      s1.last     <= row_end && col_end;
      s1.col_addr <= col;
      s1.out_row  <= OUT_POS_BITS'(row - ROW_BITS'(2));
      s1.out_col  <= OUT_POS_BITS'(col - COL_BITS'(2));
    end
  end

  // Line stores: upper row in the high byte, middle row in the low byte
  assign line_we = en && s1.valid && (s1.op == OP_PIXEL);

  lbp_ram #(
    .WIDTH (2 * PIXEL_BITS),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (line_we),
    .waddr (s1.col_addr),
    .wdata ({mid, s1.px}),
    .re    (en),
    .raddr (col),
    .rdata (line_rdata)
  );

  assign top    = line_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign mid    = line_rdata[PIXEL_BITS-1:0];
  assign centre = window[4];

  // Compare neighbors clockwise from top-left against the centre
  always_comb begin
    code[7] = window[0] >= centre;
    code[6] = window[3] >= centre;
    code[5] = top       >= centre;
    code[4] = mid       >= centre;
    code[3] = s1.px     >= centre;
    code[2] = window[5] >= centre;
    code[1] = window[2] >= centre;
    code[0] = window[1] >= centre;
  end

  // Shift the window by one column; zero it on restart
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      for (int i = 0; i < 6; i++) window[i] <= '0;
    end else if (en && s1.valid) begin
      case (s1.op)
        OP_PIXEL: begin
          window[0] <= window[3];
          window[1] <= window[4];
          window[2] <= window[5];
          window[3] <= top;
          window[4] <= mid;
          window[5] <= s1.px;
        end
        OP_CLEAR: begin
          for (int i = 0; i < 6; i++) window[i] <= '0;
        end
        default: ;
      endcase
    end
  end

  // Histogram read address: requested bin or the new code
  assign hist_raddr = (s1.op == OP_READ) ? s1.bin : code;

  // Stage 2: histogram read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (en) begin
      s2.valid <= s1.valid;
    end
    if (en) begin
      s2.inc     <= (s1.op == OP_PIXEL) && s1.interior;
      s2.rd      <= s1.op == OP_READ;
      s2.clear   <= s1.op == OP_CLEAR;
      s2.addr    <= hist_raddr;
      s2.last    <= s1.last;
      s2.out_row <= s1.out_row;
      s2.out_col <= s1.out_col;
    end
  end

  lbp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (s2.addr),
    .wdata (count_next),
    .re    (en),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Current bin count: forward the last write, unwritten bins read zero
  always_comb begin
    if (fwd_valid && (fwd_addr == s2.addr)) begin
      count = fwd_data;
    end else if (hist_valid[s2.addr]) begin
      count = hist_rdata;
    end else begin
      count = '0;
    end
    count_next = (count == COUNT_MAX) ? count : count + COUNT_BITS'(1);
  end

  assign hist_we = en && s2.valid && s2.inc;

  // Bin valid flags and forwarding register
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_valid <= '0;
      fwd_valid  <= 1'b0;
    end else if (en && s2.valid) begin
      if (s2.clear) begin
        hist_valid <= '0;
        fwd_valid  <= 1'b0;
      end else if (s2.inc) begin
        hist_valid[s2.addr] <= 1'b1;
        fwd_valid           <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      fwd_addr <= s2.addr;
      fwd_data <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= s2.valid && (s2.inc || s2.rd);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s2.rd) begin
        m_tuser <= KIND_COUNT;
        m_tlast <= 1'b0;
        m_tdata <= {OUT_CNT_BITS'(count), {(CODE_BITS + 2 * OUT_POS_BITS){1'b0}}};
      end else begin
        m_tuser <= KIND_CODE;
        m_tlast <= s2.last;
        m_tdata <= {{OUT_CNT_BITS{1'b0}}, s2.out_col, s2.out_row, s2.addr};
      end
    end
  end

endmodule
